// ===== src/deadline_ordered_present_queue_core_macros.svh =====
// Assertion macros shared by the present queue RTL.
`ifndef DEADLINE_ORDERED_PRESENT_QUEUE_CORE_MACROS_SVH
`define DEADLINE_ORDERED_PRESENT_QUEUE_CORE_MACROS_SVH

// Implication checked in the same cycle, disabled while reset is held.
`define DOPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, disabled while reset is held.
`define DOPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dopq_pkg.sv =====
// Types and constants of the deadline-ordered present queue.
`default_nettype none

package dopq_pkg;

    // Most jobs released by a single tick.
    localparam int unsigned MAX_OUT = 16;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_INSERT = 2'd1,
        OP_WIPE   = 2'd2
    } op_t;

    typedef enum logic {
        KIND_RELEASE = 1'b0,
        KIND_DROP    = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_TICK,
        ST_INS,
        ST_INS_PUT,
        ST_WIPE
    } state_t;

    // One stored job.
    typedef struct packed {
        logic [63:0] deadline;
        logic [31:0] surface;
        logic [15:0] clip_w;
        logic [15:0] clip_h;
        logic [31:0] owner;
    } entry_t;

endpackage

`default_nettype wire

// ===== src/dopq_ram.sv =====
// Job store: one write port, one read port with registered read data.
`default_nettype none

module dopq_ram
    import dopq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire entry_t                   wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/deadline_ordered_present_queue_core.sv =====
// Top level of the deadline-ordered present queue: control sequencer and result register.
// Items are taken one at a time: a new one is accepted only in idle, after the last is done.
// The job memory is walked one entry per cycle through its single read port; a tick walk
// stalls while the result register is full.
// Reset: aresetn (synchronous, active low) empties the queue, the held job and the result
// register and returns the sequencer to idle; no other register is reset.
`default_nettype none
`include "deadline_ordered_present_queue_core_macros.svh"

module deadline_ordered_present_queue_core
    import dopq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // time_ns[63:0], surface_handle[95:64], clip_w[111:96], clip_h[127:112],
    // owner[159:128]
    input  wire logic [159:0] s_tdata,
    // operation[1:0]
    input  wire logic [1:0]   s_tuser,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_surface[31:0], out_clip_width[47:32], out_clip_height[63:48], out_queue[95:64]
    output logic [95:0]       m_tdata,
    // kind[0]
    output logic [0:0]        m_tuser,
    output logic              m_tlast
);

    // IW indexes the memory; CW holds a count up to DEPTH itself.
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // The queue lives in a ring: logical position zero is the head of the
    // queue, stored at physical address head_reg. A tick then moves only the
    // head and the count, while inserts and wipes shift entries within the ring.
    function automatic logic [IW-1:0] to_phys(input logic [IW-1:0] head,
                                              input logic [CW-1:0] lg);
        logic [CW:0] s;
        s = (CW+1)'(head) + {1'b0, lg};
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    entry_t          job_reg, job_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   keep_reg, keep_next;
    entry_t          pend_reg, pend_next;
    logic            pend_vld_reg, pend_vld_next;

    logic            out_vld_reg, out_vld_next;
    kind_t           out_kind_reg, out_kind_next;
    entry_t          out_job_reg, out_job_next;
    logic            out_last_reg, out_last_next;

    logic            rd_en, wr_en;
    logic [CW-1:0]   rd_log, wr_log;
    entry_t          wr_data, rd_data;

    logic            cnt_full, out_free, tick_due, tick_hold, ins_move, wipe_keep, wipe_end;

    dopq_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(to_phys(head_reg, wr_log)),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(to_phys(head_reg, rd_log)),
        .rd_data(rd_data)
    );

    // Decisions on the entry whose read data is present this cycle.
    assign cnt_full  = (cnt_reg == CW'(DEPTH));
    assign out_free  = !out_vld_reg || m_tready;
    assign tick_due  = (idx_reg < cnt_reg) && (32'(idx_reg) < MAX_OUT)
                       && (rd_data.deadline <= job_reg.deadline);
    // A held job can only be sent once the result register has room.
    assign tick_hold = pend_vld_reg && !out_free;
    assign ins_move  = (rd_data.deadline >= job_reg.deadline);
    assign wipe_keep = (rd_data.owner != job_reg.owner);
    assign wipe_end  = ((idx_reg + CW'(1)) == cnt_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                unique case (op_reg)
                    OP_TICK: begin
                        state_next = (cnt_reg == '0) ? ST_IDLE : ST_TICK;
                    end
                    OP_INSERT: begin
                        if (cnt_full) begin
                            state_next = out_free ? ST_IDLE : ST_START;
                        end else begin
                            state_next = (cnt_reg == '0) ? ST_IDLE : ST_INS;
                        end
                    end
                    OP_WIPE: begin
                        state_next = (cnt_reg == '0) ? ST_IDLE : ST_WIPE;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_TICK: begin
                if (!tick_hold && !tick_due) begin
                    state_next = ST_IDLE;
                end
            end
            ST_INS: begin
                if (!ins_move) begin
                    state_next = ST_IDLE;
                end else if (idx_reg == CW'(1)) begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT: begin
                state_next = ST_IDLE;
            end
            ST_WIPE: begin
                if (wipe_end) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory accesses and results.
    always_comb begin
        op_next       = op_reg;
        job_next      = job_reg;
        cnt_next      = cnt_reg;
        head_next     = head_reg;
        idx_next      = idx_reg;
        keep_next     = keep_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_kind_next = out_kind_reg;
        out_job_next  = out_job_reg;
        out_last_next = out_last_reg;
        rd_en         = 1'b0;
        rd_log        = idx_reg;
        wr_en         = 1'b0;
        wr_log        = idx_reg;
        wr_data       = job_reg;
        s_tready      = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next           = op_t'(s_tuser);
                    job_next.deadline = s_tdata[63:0];
                    job_next.surface  = s_tdata[95:64];
                    job_next.clip_w   = s_tdata[111:96];
                    job_next.clip_h   = s_tdata[127:112];
                    job_next.owner    = s_tdata[159:128];
                end
            end
            ST_START: begin
                unique case (op_reg)
                    OP_TICK: begin
                        idx_next      = '0;
                        pend_vld_next = 1'b0;
                        rd_en         = (cnt_reg != '0);
                        rd_log        = '0;
                    end
                    OP_INSERT: begin
                        if (cnt_full) begin
                            // No room: hand the job straight back.
                            if (out_free) begin
                                out_vld_next  = 1'b1;
                                out_kind_next = KIND_DROP;
                                out_job_next  = job_reg;
                                out_last_next = 1'b1;
                            end
                        end else if (cnt_reg == '0) begin
                            wr_en    = 1'b1;
                            wr_log   = '0;
                            cnt_next = CW'(1);
                        end else begin
                            // Walk down from the tail, shifting later or equal deadlines up.
                            idx_next = cnt_reg;
                            rd_en    = 1'b1;
                            rd_log   = cnt_reg - CW'(1);
                        end
                    end
                    OP_WIPE: begin
                        idx_next  = '0;
                        keep_next = '0;
                        rd_en     = (cnt_reg != '0);
                        rd_log    = '0;
                    end
                    default: begin
                        op_next = op_reg;
                    end
                endcase
            end
            ST_TICK: begin
                // A due job is held back in pend_reg so that the following read
                // can tell whether it is the last one of this tick.
                if (!tick_hold) begin
                    if (pend_vld_reg) begin
                        out_vld_next  = 1'b1;
                        out_kind_next = KIND_RELEASE;
                        out_job_next  = pend_reg;
                        out_last_next = !tick_due;
                    end
                    if (tick_due) begin
                        pend_next     = rd_data;
                        pend_vld_next = 1'b1;
                        idx_next      = idx_reg + CW'(1);
                        rd_en         = 1'b1;
                        rd_log        = idx_reg + CW'(1);
                    end else begin
                        pend_vld_next = 1'b0;
                        head_next     = to_phys(head_reg, idx_reg);
                        cnt_next      = cnt_reg - idx_reg;
                    end
                end
            end
            ST_INS: begin
                if (ins_move) begin
                    wr_en    = 1'b1;
                    wr_log   = idx_reg;
                    wr_data  = rd_data;
                    idx_next = idx_reg - CW'(1);
                    if (idx_reg != CW'(1)) begin
                        rd_en  = 1'b1;
                        rd_log = idx_reg - CW'(2);
                    end
                end else begin
                    wr_en    = 1'b1;
                    wr_log   = idx_reg;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_INS_PUT: begin
                wr_en    = 1'b1;
                wr_log   = idx_reg;
                cnt_next = cnt_reg + CW'(1);
            end
            ST_WIPE: begin
                // Compact the survivors towards the head, keeping their order.
                if (wipe_keep) begin
                    wr_en     = 1'b1;
                    wr_log    = keep_reg;
                    wr_data   = rd_data;
                    keep_next = keep_reg + CW'(1);
                end
                idx_next = idx_reg + CW'(1);
                if (wipe_end) begin
                    cnt_next = keep_reg + CW'(wipe_keep);
                end else begin
                    rd_en  = 1'b1;
                    rd_log = idx_reg + CW'(1);
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            head_reg     <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            head_reg     <= head_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        job_reg      <= job_next;
        idx_reg      <= idx_next;
        keep_reg     <= keep_next;
        pend_reg     <= pend_next;
        out_kind_reg <= out_kind_next;
        out_job_reg  <= out_job_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_job_reg.owner, out_job_reg.clip_h,
                       out_job_reg.clip_w, out_job_reg.surface};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Conditions watched by the assertions below.
    logic ins_walk, held_job, drop_fire, drop_beat;

    assign ins_walk  = (state_reg == ST_INS) || (state_reg == ST_INS_PUT);
    assign held_job  = (state_reg == ST_TICK) && pend_vld_reg;
    assign drop_fire = (state_reg == ST_START) && (op_reg == OP_INSERT) && cnt_full && out_free;
    assign drop_beat = m_tvalid && m_tlast && (m_tuser == KIND_DROP);

    `DOPQ_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CW'(DEPTH), "job count above DEPTH")
    `DOPQ_ASSERT_IMPL(a_ins_room, ins_walk, !cnt_full, "insert walk on a full queue")
    `DOPQ_ASSERT_IMPL(a_wipe_keep, state_reg == ST_WIPE, keep_reg <= idx_reg, "wipe order broken")
    `DOPQ_ASSERT_IMPL(a_pend_idx, held_job, idx_reg != '0, "held job without a release count")
    `DOPQ_ASSERT_NEXT(a_drop_out, drop_fire, drop_beat, "dropped insert not reported")

endmodule

`default_nettype wire
